// File: rtl/dbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbf_pkg
// Shared constants and threshold tables for the deblocking edge filter.
// ----------------------------------------------------------------------------
package dbf_pkg;

    localparam int unsigned SAMPLE_BITS_DEF = 8;
    localparam int unsigned QP_BITS         = 6;
    localparam int unsigned STR_BITS        = 3;
    localparam logic [5:0]  QP_MAX          = 6'd51;
    localparam logic [2:0]  STR_STRONG      = 3'd4;
    localparam logic [2:0]  STR_NONE        = 3'd0;
    localparam logic        MODE_CHROMA     = 1'b1;

    typedef struct packed {
        logic [7:0] alpha;
        logic [4:0] beta;
        logic [4:0] tc0_1;
        logic [4:0] tc0_2;
        logic [4:0] tc0_3;
    } thr_t;

    // Look up alpha, beta and tc0 for a clipped quantiser
    function automatic thr_t thr_lookup(input logic [5:0] qp);
        thr_t t;
        t = '0;
        case (qp)
            6'd16: t = '{8'd4,   5'd2,  5'd0,  5'd0,  5'd0};
            6'd17: t = '{8'd4,   5'd2,  5'd0,  5'd0,  5'd1};
            6'd18: t = '{8'd5,   5'd2,  5'd0,  5'd0,  5'd1};
            6'd19: t = '{8'd6,   5'd3,  5'd0,  5'd0,  5'd1};
            6'd20: t = '{8'd7,   5'd3,  5'd0,  5'd0,  5'd1};
            6'd21: t = '{8'd8,   5'd3,  5'd0,  5'd1,  5'd1};
            6'd22: t = '{8'd9,   5'd3,  5'd0,  5'd1,  5'd1};
            6'd23: t = '{8'd10,  5'd4,  5'd1,  5'd1,  5'd1};
            6'd24: t = '{8'd12,  5'd4,  5'd1,  5'd1,  5'd1};
            6'd25: t = '{8'd13,  5'd4,  5'd1,  5'd1,  5'd1};
            6'd26: t = '{8'd15,  5'd6,  5'd1,  5'd1,  5'd1};
            6'd27: t = '{8'd17,  5'd6,  5'd1,  5'd1,  5'd2};
            6'd28: t = '{8'd20,  5'd7,  5'd1,  5'd1,  5'd2};
            6'd29: t = '{8'd22,  5'd7,  5'd1,  5'd1,  5'd2};
            6'd30: t = '{8'd25,  5'd8,  5'd1,  5'd1,  5'd2};
            6'd31: t = '{8'd28,  5'd8,  5'd1,  5'd2,  5'd3};
            6'd32: t = '{8'd32,  5'd9,  5'd1,  5'd2,  5'd3};
            6'd33: t = '{8'd36,  5'd9,  5'd2,  5'd2,  5'd3};
            6'd34: t = '{8'd40,  5'd10, 5'd2,  5'd2,  5'd4};
            6'd35: t = '{8'd45,  5'd10, 5'd2,  5'd3,  5'd4};
            6'd36: t = '{8'd50,  5'd11, 5'd2,  5'd3,  5'd4};
            6'd37: t = '{8'd56,  5'd11, 5'd3,  5'd3,  5'd5};
            6'd38: t = '{8'd63,  5'd12, 5'd3,  5'd4,  5'd6};
            6'd39: t = '{8'd71,  5'd12, 5'd3,  5'd4,  5'd6};
            6'd40: t = '{8'd80,  5'd13, 5'd4,  5'd5,  5'd7};
            6'd41: t = '{8'd90,  5'd13, 5'd4,  5'd5,  5'd8};
            6'd42: t = '{8'd101, 5'd14, 5'd4,  5'd6,  5'd9};
            6'd43: t = '{8'd113, 5'd14, 5'd5,  5'd7,  5'd10};
            6'd44: t = '{8'd127, 5'd15, 5'd6,  5'd8,  5'd11};
            6'd45: t = '{8'd144, 5'd15, 5'd6,  5'd8,  5'd13};
            6'd46: t = '{8'd162, 5'd16, 5'd7,  5'd10, 5'd14};
            6'd47: t = '{8'd182, 5'd16, 5'd8,  5'd11, 5'd16};
            6'd48: t = '{8'd203, 5'd17, 5'd9,  5'd12, 5'd18};
            6'd49: t = '{8'd226, 5'd17, 5'd10, 5'd13, 5'd20};
            6'd50: t = '{8'd255, 5'd18, 5'd11, 5'd15, 5'd23};
            6'd51: t = '{8'd255, 5'd18, 5'd13, 5'd17, 5'd25};
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

// File: rtl/dbf_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbf_core
// Three-stage filter datapath: thresholds, decisions, filter taps.
// Advances when adv is high; valid bits travel with each stage.
// ----------------------------------------------------------------------------
module dbf_core #(
    parameter int unsigned SAMPLE_BITS = dbf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_vld,
    input  logic                   mode,
    input  logic [2:0]             strength,
    input  logic [5:0]             qp_avg,
    input  logic [SAMPLE_BITS-1:0] in_p3,
    input  logic [SAMPLE_BITS-1:0] in_p2,
    input  logic [SAMPLE_BITS-1:0] in_p1,
    input  logic [SAMPLE_BITS-1:0] in_p0,
    input  logic [SAMPLE_BITS-1:0] in_q0,
    input  logic [SAMPLE_BITS-1:0] in_q1,
    input  logic [SAMPLE_BITS-1:0] in_q2,
    input  logic [SAMPLE_BITS-1:0] in_q3,
    output logic                   res_vld,
    output logic [SAMPLE_BITS-1:0] res_p2,
    output logic [SAMPLE_BITS-1:0] res_p1,
    output logic [SAMPLE_BITS-1:0] res_p0,
    output logic [SAMPLE_BITS-1:0] res_q0,
    output logic [SAMPLE_BITS-1:0] res_q1,
    output logic [SAMPLE_BITS-1:0] res_q2,
    output logic                   res_flt
);
    import dbf_pkg::*;

    localparam int unsigned W  = SAMPLE_BITS;
    localparam int unsigned SW = SAMPLE_BITS + 5;

    typedef logic [W-1:0] smp_t;
    typedef logic signed [SW-1:0] wide_t;

    typedef struct packed {
        smp_t p3, p2, p1, p0, q0, q1, q2, q3;
    } line_t;

    function automatic smp_t absd(input smp_t a, input smp_t b);
        return (a > b) ? smp_t'(a - b) : smp_t'(b - a);
    endfunction

    function automatic smp_t clip_pix(input wide_t v);
        if (v < 0)
            return '0;
        else if (v > wide_t'((1 << W) - 1))
            return '1;
        return v[W-1:0];
    endfunction

    function automatic wide_t clip_c(input wide_t v, input wide_t c);
        if (v < -c)
            return -c;
        else if (v > c)
            return c;
        return v;
    endfunction

    function automatic wide_t ext(input smp_t s);
        return wide_t'({1'b0, s});
    endfunction

    // ---------------- stage 1: clip inputs, look up thresholds
    logic        s1_vld_reg;
    line_t       s1_ln_reg;
    logic        s1_chr_reg;
    logic [2:0]  s1_bs_reg;
    thr_t        s1_thr_reg;
    logic [5:0]  qp_c;
    logic [2:0]  bs_c;

    always_comb
    begin
        qp_c = (qp_avg > QP_MAX) ? QP_MAX : qp_avg;
        bs_c = (strength > STR_STRONG) ? STR_STRONG : strength;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ln_reg  <= '{in_p3, in_p2, in_p1, in_p0, in_q0, in_q1, in_q2, in_q3};
            s1_chr_reg <= (mode == MODE_CHROMA);
            s1_bs_reg  <= bs_c;
            s1_thr_reg <= thr_lookup(qp_c);
        end
    end

    // ---------------- stage 2: activity and side decisions, pick tc0
    logic        s2_vld_reg;
    line_t       s2_ln_reg;
    logic        s2_chr_reg;
    logic        s2_strong_reg;
    logic        s2_flt_reg;
    logic        s2_ap_reg, s2_aq_reg, s2_small_reg;
    logic [4:0]  s2_c_reg;
    smp_t        d_pq;
    logic [4:0]  c_sel;
    logic        flt_c;

    always_comb
    begin
        d_pq  = absd(s1_ln_reg.p0, s1_ln_reg.q0);
        flt_c = (s1_bs_reg != STR_NONE) && (W'(d_pq) < W'(s1_thr_reg.alpha))
              && (absd(s1_ln_reg.p1, s1_ln_reg.p0) < W'(s1_thr_reg.beta))
              && (absd(s1_ln_reg.q1, s1_ln_reg.q0) < W'(s1_thr_reg.beta));
        case (s1_bs_reg)
            3'd1:    c_sel = s1_thr_reg.tc0_1;
            3'd2:    c_sel = s1_thr_reg.tc0_2;
            default: c_sel = s1_thr_reg.tc0_3;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (adv)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ln_reg     <= s1_ln_reg;
            s2_chr_reg    <= s1_chr_reg;
            s2_strong_reg <= (s1_bs_reg == STR_STRONG);
            s2_flt_reg    <= flt_c;
            s2_ap_reg     <= absd(s1_ln_reg.p2, s1_ln_reg.p0) < W'(s1_thr_reg.beta);
            s2_aq_reg     <= absd(s1_ln_reg.q2, s1_ln_reg.q0) < W'(s1_thr_reg.beta);
            s2_small_reg  <= W'(d_pq) < (W'(s1_thr_reg.alpha >> 2) + W'(2));
            s2_c_reg      <= c_sel;
        end
    end

    // ---------------- stage 3: filter taps and output select
    logic  s3_vld_reg;
    smp_t  s3_p2_reg, s3_p1_reg, s3_p0_reg, s3_q0_reg, s3_q1_reg, s3_q2_reg;
    logic  s3_flt_reg;
    smp_t  n_p2, n_p1, n_p0, n_q0, n_q1, n_q2;
    wide_t p3, p2, p1, p0, q0, q1, q2, q3, c, tc, dl, avg, t;

    always_comb
    begin
        p3 = ext(s2_ln_reg.p3); p2 = ext(s2_ln_reg.p2);
        p1 = ext(s2_ln_reg.p1); p0 = ext(s2_ln_reg.p0);
        q0 = ext(s2_ln_reg.q0); q1 = ext(s2_ln_reg.q1);
        q2 = ext(s2_ln_reg.q2); q3 = ext(s2_ln_reg.q3);
        c  = wide_t'({1'b0, s2_c_reg});
        n_p2 = s2_ln_reg.p2; n_p1 = s2_ln_reg.p1; n_p0 = s2_ln_reg.p0;
        n_q0 = s2_ln_reg.q0; n_q1 = s2_ln_reg.q1; n_q2 = s2_ln_reg.q2;
        tc = s2_chr_reg ? c + wide_t'(1)
                        : c + wide_t'(s2_ap_reg) + wide_t'(s2_aq_reg);
        dl = clip_c(wide_t'(((q0 - p0) * 4 + (p1 - q1) + 4) >>> 3), tc);
        avg = wide_t'((p0 + q0 + 1) >>> 1);
        t  = '0;
        if (s2_flt_reg)
        begin
            if (s2_strong_reg)
            begin
                if (!s2_chr_reg && s2_ap_reg && s2_small_reg)
                begin
                    t    = wide_t'((p2 + 2*p1 + 2*p0 + 2*q0 + q1 + 4) >>> 3);
                    n_p0 = t[W-1:0];
                    t    = wide_t'((p2 + p1 + p0 + q0 + 2) >>> 2);
                    n_p1 = t[W-1:0];
                    t    = wide_t'((2*p3 + 3*p2 + p1 + p0 + q0 + 4) >>> 3);
                    n_p2 = t[W-1:0];
                end
                else
                begin
                    t    = wide_t'((2*p1 + p0 + q1 + 2) >>> 2);
                    n_p0 = t[W-1:0];
                end
                if (!s2_chr_reg && s2_aq_reg && s2_small_reg)
                begin
                    t    = wide_t'((p1 + 2*p0 + 2*q0 + 2*q1 + q2 + 4) >>> 3);
                    n_q0 = t[W-1:0];
                    t    = wide_t'((p0 + q0 + q1 + q2 + 2) >>> 2);
                    n_q1 = t[W-1:0];
                    t    = wide_t'((2*q3 + 3*q2 + q1 + q0 + p0 + 4) >>> 3);
                    n_q2 = t[W-1:0];
                end
                else
                begin
                    t    = wide_t'((2*q1 + q0 + p1 + 2) >>> 2);
                    n_q0 = t[W-1:0];
                end
            end
            else
            begin
                n_p0 = clip_pix(p0 + dl);
                n_q0 = clip_pix(q0 - dl);
                if (!s2_chr_reg && s2_ap_reg)
                    n_p1 = clip_pix(p1 + clip_c(wide_t'((p2 + avg - 2*p1) >>> 1), c));
                if (!s2_chr_reg && s2_aq_reg)
                    n_q1 = clip_pix(q1 + clip_c(wide_t'((q2 + avg - 2*q1) >>> 1), c));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (adv)
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_p2_reg  <= n_p2; s3_p1_reg <= n_p1; s3_p0_reg <= n_p0;
            s3_q0_reg  <= n_q0; s3_q1_reg <= n_q1; s3_q2_reg <= n_q2;
            s3_flt_reg <= s2_flt_reg;
        end
    end

    assign res_vld = s3_vld_reg;
    assign res_p2  = s3_p2_reg;
    assign res_p1  = s3_p1_reg;
    assign res_p0  = s3_p0_reg;
    assign res_q0  = s3_q0_reg;
    assign res_q1  = s3_q1_reg;
    assign res_q2  = s3_q2_reg;
    assign res_flt = s3_flt_reg;

endmodule

// File: rtl/deblocking_edge_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deblocking_edge_filter_top
// Filters one line of samples across a luma or chroma block edge.
//
//   channel  valid      stall      payload
//   input    in_valid   in_stall   mode, strength, qp_avg, in_p3..in_q3
//   output   out_valid  out_stall  out_p2..out_q2, edge_filtered
//
// Reset clears all stage valid bits. One transaction per cycle unless the
// pipeline holds, passing the thresholds, decision and filter-tap stages.
// The whole pipeline holds while out_stall is high and the last stage is
// full; in_stall follows that condition, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module deblocking_edge_filter_top #(
    parameter int unsigned SAMPLE_BITS = dbf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   mode,
    input  logic [2:0]             strength,
    input  logic [5:0]             qp_avg,
    input  logic [SAMPLE_BITS-1:0] in_p3,
    input  logic [SAMPLE_BITS-1:0] in_p2,
    input  logic [SAMPLE_BITS-1:0] in_p1,
    input  logic [SAMPLE_BITS-1:0] in_p0,
    input  logic [SAMPLE_BITS-1:0] in_q0,
    input  logic [SAMPLE_BITS-1:0] in_q1,
    input  logic [SAMPLE_BITS-1:0] in_q2,
    input  logic [SAMPLE_BITS-1:0] in_q3,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SAMPLE_BITS-1:0] out_p2,
    output logic [SAMPLE_BITS-1:0] out_p1,
    output logic [SAMPLE_BITS-1:0] out_p0,
    output logic [SAMPLE_BITS-1:0] out_q0,
    output logic [SAMPLE_BITS-1:0] out_q1,
    output logic [SAMPLE_BITS-1:0] out_q2,
    output logic                   edge_filtered
);
    import dbf_pkg::*;

    logic adv;

    // Advance unless a finished result is held by the consumer
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    dbf_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (in_valid),
        .mode     (mode),
        .strength (strength),
        .qp_avg   (qp_avg),
        .in_p3    (in_p3),
        .in_p2    (in_p2),
        .in_p1    (in_p1),
        .in_p0    (in_p0),
        .in_q0    (in_q0),
        .in_q1    (in_q1),
        .in_q2    (in_q2),
        .in_q3    (in_q3),
        .res_vld  (out_valid),
        .res_p2   (out_p2),
        .res_p1   (out_p1),
        .res_p0   (out_p0),
        .res_q0   (out_q0),
        .res_q1   (out_q1),
        .res_q2   (out_q2),
        .res_flt  (edge_filtered)
    );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the deblocking edge filter. Edge lines (directed
// corner cases, then random smooth and noisy lines) are driven through the
// valid/stall input channel. A scoreboard computes the filtered samples of
// each accepted line and compares them with every accepted output.
// ----------------------------------------------------------------------------

typedef struct {
    logic [7:0] p2;
    logic [7:0] p1;
    logic [7:0] p0;
    logic [7:0] q0;
    logic [7:0] q1;
    logic [7:0] q2;
    logic       filt;
} edge_line_t;

class edge_scoreboard;
    edge_line_t pending[$];
    int         errors;

    function new();
        errors = 0;
    endfunction

    static function int adiff(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    static function int clip(int lo, int hi, int v);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Compute the filtered line and queue it
    function void note_line(logic chroma, logic [2:0] bs_in, logic [5:0] qp_in,
                            logic [7:0] ip3, logic [7:0] ip2, logic [7:0] ip1,
                            logic [7:0] ip0, logic [7:0] iq0, logic [7:0] iq1,
                            logic [7:0] iq2, logic [7:0] iq3);
        int alpha_t[52] = '{0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
            4,4,5,6,7,8,9,10,12,13,15,17,20,22,25,28,
            32,36,40,45,50,56,63,71,80,90,101,113,127,144,162,182,203,226,255,255};
        int beta_t[52] = '{0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
            2,2,2,3,3,3,3,4,4,4,6,6,7,7,8,8,
            9,9,10,10,11,11,12,12,13,13,14,14,15,15,16,16,17,17,18,18};
        int tc_t[52][3] = '{'{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0},
            '{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0},
            '{0,0,0},'{0,0,0},'{0,0,0},'{0,0,0},'{0,0,1},'{0,0,1},'{0,0,1},
            '{0,0,1},'{0,1,1},'{0,1,1},'{1,1,1},'{1,1,1},'{1,1,1},'{1,1,1},
            '{1,1,2},'{1,1,2},'{1,1,2},'{1,1,2},'{1,2,3},'{1,2,3},'{2,2,3},
            '{2,2,4},'{2,3,4},'{2,3,4},'{3,3,5},'{3,4,6},'{3,4,6},'{4,5,7},
            '{4,5,8},'{4,6,9},'{5,7,10},'{6,8,11},'{6,8,13},'{7,10,14},
            '{8,11,16},'{9,12,18},'{10,13,20},'{11,15,23},'{13,17,25}};
        int p3, p2, p1, p0, q0, q1, q2, q3, bs, idx, a, b, ap, aq, c, tc, dl, avg;
        bit sm;
        edge_line_t r;
        p3 = ip3; p2 = ip2; p1 = ip1; p0 = ip0;
        q0 = iq0; q1 = iq1; q2 = iq2; q3 = iq3;
        bs = (bs_in > dbf_pkg::STR_STRONG) ? 4 : bs_in;
        idx = (qp_in > dbf_pkg::QP_MAX) ? 51 : qp_in;
        a = alpha_t[idx];
        b = beta_t[idx];
        ap = adiff(p2, p0);
        aq = adiff(q2, q0);
        r = '{ip2, ip1, ip0, iq0, iq1, iq2, 1'b0};
        r.filt = (bs != 0) && adiff(p0, q0) < a && adiff(p1, p0) < b &&
                 adiff(q1, q0) < b;
        if (r.filt && bs == 4) begin
            sm = adiff(p0, q0) < ((a >> 2) + 2);
            if (!chroma && ap < b && sm) begin
                r.p0 = 8'((p2 + 2*p1 + 2*p0 + 2*q0 + q1 + 4) >> 3);
                r.p1 = 8'((p2 + p1 + p0 + q0 + 2) >> 2);
                r.p2 = 8'((2*p3 + 3*p2 + p1 + p0 + q0 + 4) >> 3);
            end
            else
                r.p0 = 8'((2*p1 + p0 + q1 + 2) >> 2);
            if (!chroma && aq < b && sm) begin
                r.q0 = 8'((p1 + 2*p0 + 2*q0 + 2*q1 + q2 + 4) >> 3);
                r.q1 = 8'((p0 + q0 + q1 + q2 + 2) >> 2);
                r.q2 = 8'((2*q3 + 3*q2 + q1 + q0 + p0 + 4) >> 3);
            end
            else
                r.q0 = 8'((2*q1 + q0 + p1 + 2) >> 2);
        end
        else if (r.filt) begin
            c = tc_t[idx][bs-1];
            tc = chroma ? c + 1 : c + (ap < b) + (aq < b);
            // >>> on int floors toward minus infinity
            dl = clip(-tc, tc, ((q0 - p0)*4 + (p1 - q1) + 4) >>> 3);
            r.p0 = 8'(clip(0, 255, p0 + dl));
            r.q0 = 8'(clip(0, 255, q0 - dl));
            if (!chroma) begin
                avg = (p0 + q0 + 1) >> 1;
                if (ap < b)
                    r.p1 = 8'(clip(0, 255, p1 + clip(-c, c, (p2 + avg - 2*p1) >>> 1)));
                if (aq < b)
                    r.q1 = 8'(clip(0, 255, q1 + clip(-c, c, (q2 + avg - 2*q1) >>> 1)));
            end
        end
        pending.push_back(r);
    endfunction

    // Compare one output line with the oldest expectation
    function void check_line(edge_line_t got);
        edge_line_t e;
        if (pending.size() == 0) begin
            $error("unexpected output line");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.p2 !== e.p2) begin $error("out_p2 exp %0d got %0d", e.p2, got.p2); errors++; end
        if (got.p1 !== e.p1) begin $error("out_p1 exp %0d got %0d", e.p1, got.p1); errors++; end
        if (got.p0 !== e.p0) begin $error("out_p0 exp %0d got %0d", e.p0, got.p0); errors++; end
        if (got.q0 !== e.q0) begin $error("out_q0 exp %0d got %0d", e.q0, got.q0); errors++; end
        if (got.q1 !== e.q1) begin $error("out_q1 exp %0d got %0d", e.q1, got.q1); errors++; end
        if (got.q2 !== e.q2) begin $error("out_q2 exp %0d got %0d", e.q2, got.q2); errors++; end
        if (got.filt !== e.filt)
        begin
            $error("edge_filtered exp %0d got %0d", e.filt, got.filt);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import dbf_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       mode = 1'b0;
    logic [2:0] strength = '0;
    logic [5:0] qp_avg = '0;
    logic [7:0] in_p3 = '0, in_p2 = '0, in_p1 = '0, in_p0 = '0;
    logic [7:0] in_q0 = '0, in_q1 = '0, in_q2 = '0, in_q3 = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_p2, out_p1, out_p0, out_q0, out_q1, out_q2;
    logic       edge_filtered;

    int send_idle_pct = 13;
    int recv_idle_pct = 64;
    int idle_cycles = 0;
    edge_scoreboard sb = new();

    always #1 clk = ~clk;

    deblocking_edge_filter_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .strength(strength), .qp_avg(qp_avg),
        .in_p3(in_p3), .in_p2(in_p2), .in_p1(in_p1), .in_p0(in_p0),
        .in_q0(in_q0), .in_q1(in_q1), .in_q2(in_q2), .in_q3(in_q3),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_p2(out_p2), .out_p1(out_p1), .out_p0(out_p0),
        .out_q0(out_q0), .out_q1(out_q1), .out_q2(out_q2),
        .edge_filtered(edge_filtered)
    );

    // Note accepted inputs, check accepted outputs, toggle receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_line(mode, strength, qp_avg, in_p3, in_p2, in_p1, in_p0,
                             in_q0, in_q1, in_q2, in_q3);
            if (out_valid && !out_stall)
                sb.check_line('{out_p2, out_p1, out_p0, out_q0, out_q1, out_q2,
                                edge_filtered});
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: end the run after too long without a transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Drive one line and hold it until accepted
    task automatic send_line(logic m, logic [2:0] s, logic [5:0] qp,
                             logic [7:0] v[8]);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m; strength <= s; qp_avg <= qp;
        in_p3 <= v[0]; in_p2 <= v[1]; in_p1 <= v[2]; in_p0 <= v[3];
        in_q0 <= v[4]; in_q1 <= v[5]; in_q2 <= v[6]; in_q3 <= v[7];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Random line; smooth lines stay within a small spread to pass activity test
    task automatic send_random();
        logic [7:0] v[8];
        int base, spread, smp;
        logic [2:0] s;
        logic [5:0] qp;
        s = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
        qp = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(51, 16));
        if ($urandom_range(3) != 0)
        begin
            spread = $urandom_range(1, 24);
            base = $urandom_range(255);
            foreach (v[i])
            begin
                smp = base + int'($urandom_range(2*spread)) - spread;
                v[i] = (smp < 0) ? 8'd0 : ((smp > 255) ? 8'd255 : 8'(smp));
            end
        end
        else
            foreach (v[i]) v[i] = 8'($urandom);
        send_line(1'($urandom_range(1)), s, qp, v);
    endtask

    initial
    begin
        logic [7:0] v[8];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every strength, both modes, qp clipping
        v = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        send_line(1'b0, STR_NONE, 6'd0, v);
        v = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
        send_line(1'b1, 3'd7, 6'd63, v);
        for (int s = 0; s <= 7; s++)
        begin
            v = '{8'd100, 8'd102, 8'd104, 8'd106, 8'd112, 8'd113, 8'd111, 8'd110};
            send_line(1'b0, 3'(s), 6'd40, v);
            send_line(MODE_CHROMA, 3'(s), 6'd51, v);
        end
        // Strong filter fallback on one side only
        v = '{8'd90, 8'd80, 8'd100, 8'd101, 8'd103, 8'd104, 8'd104, 8'd104};
        send_line(1'b0, STR_STRONG, 6'd45, v);
        // Clipping near the top and bottom of range
        v = '{8'd255, 8'd250, 8'd252, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255};
        send_line(1'b0, 3'd3, 6'd51, v);
        v = '{8'd0, 8'd3, 8'd1, 8'd0, 8'd6, 8'd4, 8'd9, 8'd0};
        send_line(1'b0, 3'd2, 6'd60, v);
        v = '{8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85};
        send_line(1'b0, STR_STRONG, 6'd51, v);

        // Random phases with different idling, draining before each change
        for (int ph = 0; ph < 3; ph++)
        begin
            for (int n = 0; n < 143; n++)
                send_random();
            in_valid <= 1'b0;
            @(posedge clk);
            while (sb.pending.size() != 0)
                @(posedge clk);
            send_idle_pct = (ph == 0) ? 64 : 0;
            recv_idle_pct = (ph == 0) ? 13 : 0;
        end

        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: files.f
rtl/dbf_pkg.sv
rtl/dbf_core.sv
rtl/deblocking_edge_filter_top.sv
bench/tb_top.sv
